// File: sv/vwadpcm_pkg.sv
// Shared types, constants and the step table of the variable-width ADPCM decoder.
`default_nettype none

package vwadpcm_pkg;

  localparam int STEP_TABLE_DEPTH = 89;
  localparam int STEP_INDEX_MAX   = STEP_TABLE_DEPTH - 1;
  localparam int OUTPUT_SCALE     = 16;

  localparam int INDEX_W = 7;   // step index and its bounds
  localparam int PRED_W  = 12;  // predictor and its bounds
  localparam int STEP_W  = 15;  // step table entry
  localparam int ACC_W   = 16;  // difference magnitude, at most 61436
  localparam int SUM_W   = 19;  // shared adder, predictor plus signed difference
  localparam int PCM_W   = 16;
  localparam int SCALE_W = PRED_W + 5;  // scaled predictor before saturation
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INITIAL_STEP_INDEX  = 3'd0,
    CFG_WIDE_CODE_THRESHOLD = 3'd1,
    CFG_STEP_INDEX_FLOOR    = 3'd2,
    CFG_STEP_INDEX_CEILING  = 3'd3,
    CFG_PREDICTOR_FLOOR     = 3'd4,
    CFG_PREDICTOR_CEILING   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACC,
    ST_APPLY
  } dec_state_t;

  // Standard IMA step table; indexes past the end read the last entry.
  function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
    logic [STEP_W-1:0] v;
    unique case (idx)
      7'd0:  v = 15'd7;     7'd1:  v = 15'd8;     7'd2:  v = 15'd9;     7'd3:  v = 15'd10;
      7'd4:  v = 15'd11;    7'd5:  v = 15'd12;    7'd6:  v = 15'd13;    7'd7:  v = 15'd14;
      7'd8:  v = 15'd16;    7'd9:  v = 15'd17;    7'd10: v = 15'd19;    7'd11: v = 15'd21;
      7'd12: v = 15'd23;    7'd13: v = 15'd25;    7'd14: v = 15'd28;    7'd15: v = 15'd31;
      7'd16: v = 15'd34;    7'd17: v = 15'd37;    7'd18: v = 15'd41;    7'd19: v = 15'd45;
      7'd20: v = 15'd50;    7'd21: v = 15'd55;    7'd22: v = 15'd60;    7'd23: v = 15'd66;
      7'd24: v = 15'd73;    7'd25: v = 15'd80;    7'd26: v = 15'd88;    7'd27: v = 15'd97;
      7'd28: v = 15'd107;   7'd29: v = 15'd118;   7'd30: v = 15'd130;   7'd31: v = 15'd143;
      7'd32: v = 15'd157;   7'd33: v = 15'd173;   7'd34: v = 15'd190;   7'd35: v = 15'd209;
      7'd36: v = 15'd230;   7'd37: v = 15'd253;   7'd38: v = 15'd279;   7'd39: v = 15'd307;
      7'd40: v = 15'd337;   7'd41: v = 15'd371;   7'd42: v = 15'd408;   7'd43: v = 15'd449;
      7'd44: v = 15'd494;   7'd45: v = 15'd544;   7'd46: v = 15'd598;   7'd47: v = 15'd658;
      7'd48: v = 15'd724;   7'd49: v = 15'd796;   7'd50: v = 15'd876;   7'd51: v = 15'd963;
      7'd52: v = 15'd1060;  7'd53: v = 15'd1166;  7'd54: v = 15'd1282;  7'd55: v = 15'd1411;
      7'd56: v = 15'd1552;  7'd57: v = 15'd1707;  7'd58: v = 15'd1878;  7'd59: v = 15'd2066;
      7'd60: v = 15'd2272;  7'd61: v = 15'd2499;  7'd62: v = 15'd2749;  7'd63: v = 15'd3024;
      7'd64: v = 15'd3327;  7'd65: v = 15'd3660;  7'd66: v = 15'd4026;  7'd67: v = 15'd4428;
      7'd68: v = 15'd4871;  7'd69: v = 15'd5358;  7'd70: v = 15'd5894;  7'd71: v = 15'd6484;
      7'd72: v = 15'd7132;  7'd73: v = 15'd7845;  7'd74: v = 15'd8630;  7'd75: v = 15'd9493;
      7'd76: v = 15'd10442; 7'd77: v = 15'd11487; 7'd78: v = 15'd12635; 7'd79: v = 15'd13899;
      7'd80: v = 15'd15289; 7'd81: v = 15'd16818; 7'd82: v = 15'd18500; 7'd83: v = 15'd20350;
      7'd84: v = 15'd22385; 7'd85: v = 15'd24623; 7'd86: v = 15'd27086; 7'd87: v = 15'd29794;
      default: v = 15'd32767;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/variable_width_adpcm_decoder.sv
// Variable-width IMA-style ADPCM decoder: one coded byte in, two to four PCM words out.
// A word passes a fetch, two adder passes for a 2-bit code or four for a 4-bit code,
// and an update that emits it; output stalls hold the update.
// A new byte is taken only once the decoder is idle again after the previous byte.
// Reset (rst, synchronous): control regs take defaults, predictor 0, step index 40.
`default_nettype none

module variable_width_adpcm_decoder
  import vwadpcm_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Coded byte channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    coded_byte,
  input  wire logic                          track_start,
  // PCM sample channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [PCM_W-1:0]            pcm_sample,
  output logic                               last_of_byte,
  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam logic [INDEX_W-1:0] INDEX_MAX = INDEX_W'(STEP_INDEX_MAX);
  localparam logic [INDEX_W-1:0] INITIAL_STEP_RESET = 7'd40;
  localparam logic [1:0] TERM_LAST_WIDE   = 2'd3;
  localparam logic [1:0] TERM_LAST_NARROW = 2'd1;
  localparam logic signed [PCM_W-1:0] PCM_MAX = {1'b0, {(PCM_W-1){1'b1}}};
  localparam logic signed [PCM_W-1:0] PCM_MIN = {1'b1, {(PCM_W-1){1'b0}}};

  // Configuration registers.
  logic [INDEX_W-1:0]       track_start_index;
  logic [INDEX_W-1:0]       wide_code_threshold;
  logic [INDEX_W-1:0]       step_index_floor;
  logic [INDEX_W-1:0]       step_index_ceiling;
  logic signed [PRED_W-1:0] predictor_floor;
  logic signed [PRED_W-1:0] predictor_ceiling;

  // Decoder state carried from sample to sample.
  logic signed [PRED_W-1:0] predictor;
  logic [INDEX_W-1:0]       step_position;

  // Per-byte and per-sample working registers.
  dec_state_t        state, state_next;
  logic [7:0]        bits;      // codes not yet decoded, next one in the low bits
  logic [3:0]        bit_pos;   // bits consumed so far, 0 to 8
  logic [3:0]        code;
  logic              wide;
  logic              last_code;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  acc;       // difference magnitude being built
  logic [1:0]        term;

  // Sequencer controls.
  logic fetch_en, acc_en, apply_en, out_free, accept;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready. Writes are expected only while no byte is
  // in flight; they take effect at the next track start, code fetch or sample update.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_start_index   <= INITIAL_STEP_RESET;
      wide_code_threshold <= 7'd18;
      step_index_floor    <= 7'd0;
      step_index_ceiling  <= 7'd79;
      predictor_floor     <= {1'b1, {(PRED_W-1){1'b0}}};
      predictor_ceiling   <= {1'b0, {(PRED_W-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INITIAL_STEP_INDEX:  track_start_index   <= cfg_data[INDEX_W-1:0];
        CFG_WIDE_CODE_THRESHOLD: wide_code_threshold <= cfg_data[INDEX_W-1:0];
        CFG_STEP_INDEX_FLOOR:    step_index_floor    <= cfg_data[INDEX_W-1:0];
        CFG_STEP_INDEX_CEILING:  step_index_ceiling  <= cfg_data[INDEX_W-1:0];
        CFG_PREDICTOR_FLOOR:     predictor_floor     <= $signed(cfg_data[PRED_W-1:0]);
        CFG_PREDICTOR_CEILING:   predictor_ceiling   <= $signed(cfg_data[PRED_W-1:0]);
        default: ;  // indexes past the register list are ignored
      endcase
    end
  end

  // The start index saturates at the top of the step table.
  logic [INDEX_W-1:0] start_index;
  assign start_index = (track_start_index > INDEX_MAX) ? INDEX_MAX : track_start_index;

  // ---------------------------------------------------------------------------
  // Code selection: a 4-bit code needs the step index at or above the threshold
  // and at least four bits left in the byte; otherwise the code is two bits.
  // ---------------------------------------------------------------------------
  logic       wide_now;
  logic [3:0] bit_pos_step;
  assign wide_now     = (step_position >= wide_code_threshold) && (bit_pos <= 4'd4);
  assign bit_pos_step = bit_pos + (wide_now ? 4'd4 : 4'd2);

  // ---------------------------------------------------------------------------
  // Shared adder. During accumulation it adds one shifted copy of the step to the
  // magnitude each cycle; in the update cycle it adds the signed difference to
  // the predictor, negating through the carry input.
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]        addend;
  logic                     negate;
  logic signed [SUM_W-1:0]  add_a, add_b, add_sum;
  logic                     add_cin;

  assign negate = wide ? code[3] : code[1];

  always_comb begin
    unique case (term)
      2'd0:    addend = step >> 3;
      2'd1:    addend = code[0] ? (wide ? (step >> 2) : step) : '0;
      2'd2:    addend = (wide && code[1]) ? (step >> 1) : '0;
      default: addend = (wide && code[2]) ? step : '0;
    endcase
  end

  always_comb begin
    if (state == ST_APPLY) begin
      add_a   = SUM_W'(predictor);
      add_b   = negate ? ~SUM_W'(acc) : SUM_W'(acc);
      add_cin = negate;
    end else begin
      add_a   = SUM_W'(acc);
      add_b   = SUM_W'(addend);
      add_cin = 1'b0;
    end
  end

  assign add_sum = add_a + add_b + {{(SUM_W-1){1'b0}}, add_cin};

  // ---------------------------------------------------------------------------
  // Update: step index moves by the index table and is clamped floor first, then
  // ceiling, then to the table; the predictor is clamped floor first, then
  // ceiling, so the ceiling wins when the bounds cross.
  // ---------------------------------------------------------------------------
  logic signed [INDEX_W:0] idx_delta, idx_raw, idx_lo, idx_hi, idx_tab, idx_fin;
  logic signed [INDEX_W:0] idx_floor_s, idx_ceil_s;
  logic [INDEX_W-1:0]      step_position_next;
  logic signed [SUM_W-1:0] pred_lo, pred_hi;
  logic signed [PRED_W-1:0] predictor_next;
  logic signed [SCALE_W-1:0] scaled;
  logic signed [PCM_W-1:0]   pcm_next;

  always_comb begin
    if (wide) begin
      // A set magnitude bit moves the index up by 2, 4, 6 or 8.
      idx_delta = code[2] ? $signed({4'b0000, code[1:0], 1'b0} + 8'd2) : -8'sd1;
    end else begin
      idx_delta = code[0] ? 8'sd2 : -8'sd1;
    end
    idx_raw     = $signed({1'b0, step_position}) + idx_delta;
    idx_floor_s = $signed({1'b0, step_index_floor});
    idx_ceil_s  = $signed({1'b0, step_index_ceiling});
    idx_lo      = (idx_raw < idx_floor_s) ? idx_floor_s : idx_raw;
    idx_hi      = (idx_lo > idx_ceil_s) ? idx_ceil_s : idx_lo;
    idx_tab     = (idx_hi > $signed({1'b0, INDEX_MAX})) ? $signed({1'b0, INDEX_MAX}) : idx_hi;
    idx_fin     = (idx_tab < 0) ? '0 : idx_tab;
    step_position_next = idx_fin[INDEX_W-1:0];

    pred_lo = (add_sum < SUM_W'(predictor_floor)) ? SUM_W'(predictor_floor) : add_sum;
    pred_hi = (pred_lo > SUM_W'(predictor_ceiling)) ? SUM_W'(predictor_ceiling) : pred_lo;
    predictor_next = pred_hi[PRED_W-1:0];

    scaled = SCALE_W'(predictor_next) * $signed(SCALE_W'(OUTPUT_SCALE));
    if (scaled > SCALE_W'(PCM_MAX)) begin
      pcm_next = PCM_MAX;
    end else if (scaled < SCALE_W'(PCM_MIN)) begin
      pcm_next = PCM_MIN;
    end else begin
      pcm_next = scaled[PCM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: idle, fetch step and code, accumulate, update and emit.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_ACC;
      ST_ACC:   if (term == (wide ? TERM_LAST_WIDE : TERM_LAST_NARROW)) state_next = ST_APPLY;
      ST_APPLY: if (out_free) state_next = last_code ? ST_IDLE : ST_FETCH;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    fetch_en = (state == ST_FETCH);
    acc_en   = (state == ST_ACC);
    apply_en = (state == ST_APPLY) && out_free;
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Predictor and step index.
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor     <= '0;
      step_position <= INITIAL_STEP_RESET;
    end else if (accept && track_start) begin
      predictor     <= '0;
      step_position <= start_index;
    end else if (apply_en) begin
      predictor     <= predictor_next;
      step_position <= step_position_next;
    end
  end

  // Working registers of the byte being decoded.
  always_ff @(posedge clk) begin
    if (accept) begin
      bits    <= coded_byte;
      bit_pos <= '0;
    end
    if (fetch_en) begin
      step      <= step_lookup(step_position);
      wide      <= wide_now;
      code      <= wide_now ? bits[3:0] : {2'b00, bits[1:0]};
      bits      <= wide_now ? (bits >> 4) : (bits >> 2);
      bit_pos   <= bit_pos_step;
      last_code <= (bit_pos_step >= 4'd8);
      acc       <= '0;
      term      <= '0;
    end
    if (acc_en) begin
      acc  <= add_sum[ACC_W-1:0];
      term <= term + 2'd1;
    end
  end

  // Output register: holds a sample until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en) begin
      pcm_sample   <= pcm_next;
      last_of_byte <= last_code;
    end
  end

`ifndef ASSERT_OFF
  a_step_in_table: assert property (@(posedge clk) disable iff (rst)
    step_position <= INDEX_MAX)
    else $error("step index left the step table");

  a_bit_pos_even: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (!bit_pos[0] && bit_pos <= 4'd8))
    else $error("bit position out of range");

  a_word_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_APPLY))
    else $error("sample word appeared outside the update cycle");

  a_last_ends_byte: assert property (@(posedge clk) disable iff (rst)
    (apply_en && last_code) |=> (state == ST_IDLE && out_valid && last_of_byte))
    else $error("final sample did not end the byte");

  a_pred_bounds: assert property (@(posedge clk) disable iff (rst)
    (apply_en && predictor_floor <= predictor_ceiling) |=>
      (predictor >= $past(predictor_floor) && predictor <= $past(predictor_ceiling)))
    else $error("predictor escaped its bounds");
`endif

endmodule

`default_nettype wire

// File: verif/adpcm_word_checker.sv
// Checker for the ADPCM decoder: tracks the decoder state, predicts each PCM word and compares.
module adpcm_word_checker
  import vwadpcm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [7:0]             coded_byte,
  input  wire logic                   track_start,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic signed [PCM_W-1:0] pcm_sample,
  input  wire logic                   last_of_byte,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending_words,
  output int                          checked_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [INDEX_W-1:0]       RESET_INIT_INDEX = 7'd40;
  localparam logic [INDEX_W-1:0]       RESET_THRESHOLD  = 7'd18;
  localparam logic [INDEX_W-1:0]       RESET_INDEX_LO   = 7'd0;
  localparam logic [INDEX_W-1:0]       RESET_INDEX_HI   = 7'd79;
  localparam logic signed [PRED_W-1:0] RESET_PRED_LO    = -12'sd2048;
  localparam logic signed [PRED_W-1:0] RESET_PRED_HI    = 12'sd2047;

  typedef struct packed {
    logic signed [PCM_W-1:0] sample;
    logic                    last;
  } pcm_word_t;

  int ima_steps [STEP_TABLE_DEPTH] = '{
    7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31,
    34, 37, 41, 45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143,
    157, 173, 190, 209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
    724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272, 2499,
    2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132, 7845, 8630,
    9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500, 20350, 22385, 24623,
    27086, 29794, 32767
  };

  pcm_word_t expected_words[$];

  logic [INDEX_W-1:0]       init_index, wide_threshold, index_lo, index_hi;
  logic signed [PRED_W-1:0] pred_lo, pred_hi;
  logic signed [PRED_W-1:0] predictor;
  logic [INDEX_W-1:0]       cur_index;
  int                       errors, words_seen;

  function automatic void write_register(input logic [CFG_INDEX_W-1:0] slot,
                                         input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(slot))
      CFG_INITIAL_STEP_INDEX:  init_index = data[INDEX_W-1:0];
      CFG_WIDE_CODE_THRESHOLD: wide_threshold = data[INDEX_W-1:0];
      CFG_STEP_INDEX_FLOOR:    index_lo = data[INDEX_W-1:0];
      CFG_STEP_INDEX_CEILING:  index_hi = data[INDEX_W-1:0];
      CFG_PREDICTOR_FLOOR:     pred_lo = data;
      CFG_PREDICTOR_CEILING:   pred_hi = data;
      default: ;
    endcase
  endfunction

  // Decodes one byte from the low bits upward and queues every PCM word it yields.
  function automatic void predict_byte(input logic [7:0] byte_in, input logic new_track);
    int        bits_used, code, step, diff, idx, pred, pcm;
    logic [7:0] rest;
    pcm_word_t w;
    rest = byte_in;
    bits_used = 0;
    if (new_track) begin
      predictor = '0;
      cur_index = (init_index > STEP_INDEX_MAX) ? INDEX_W'(STEP_INDEX_MAX) : init_index;
    end
    while (bits_used < 8) begin
      step = ima_steps[cur_index];
      diff = step >>> 3;
      idx = int'(cur_index);
      // Wide codes need the index at or above the threshold and four bits left in the byte.
      if (cur_index < wide_threshold || bits_used > 4) begin
        code = rest[1:0];
        if (code[0]) diff += step;
        if (code[1]) diff = -diff;
        idx += code[0] ? 2 : -1;
        rest = rest >> 2;
        bits_used += 2;
      end else begin
        code = rest[3:0];
        if (code[0]) diff += step >>> 2;
        if (code[1]) diff += step >>> 1;
        if (code[2]) diff += step;
        if (code[3]) diff = -diff;
        idx += code[2] ? 2 * (code % 4 + 1) : -1;
        rest = rest >> 4;
        bits_used += 4;
      end
      // Floor before ceiling, so the ceiling wins when the bounds cross.
      if (idx < int'(index_lo)) idx = int'(index_lo);
      if (idx > int'(index_hi)) idx = int'(index_hi);
      if (idx > STEP_INDEX_MAX) idx = STEP_INDEX_MAX;
      if (idx < 0) idx = 0;
      cur_index = idx[INDEX_W-1:0];
      pred = int'(predictor) + diff;
      if (pred < int'(pred_lo)) pred = int'(pred_lo);
      if (pred > int'(pred_hi)) pred = int'(pred_hi);
      predictor = pred[PRED_W-1:0];
      pcm = pred * OUTPUT_SCALE;
      if (pcm > 32767) pcm = 32767;
      if (pcm < -32768) pcm = -32768;
      w.sample = pcm[PCM_W-1:0];
      w.last = (bits_used >= 8);
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    pcm_word_t want;
    if (rst) begin
      init_index = RESET_INIT_INDEX;
      wide_threshold = RESET_THRESHOLD;
      index_lo = RESET_INDEX_LO;
      index_hi = RESET_INDEX_HI;
      pred_lo = RESET_PRED_LO;
      pred_hi = RESET_PRED_HI;
      predictor = '0;
      cur_index = RESET_INIT_INDEX;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got pcm_sample %0d last_of_byte %0b",
                   $time, pcm_sample, last_of_byte);
        end else begin
          want = expected_words.pop_front();
          if (pcm_sample !== want.sample) begin
            errors++;
            $display("%0t: pcm_sample expected %0d, got %0d", $time, want.sample, pcm_sample);
          end
          if (last_of_byte !== want.last) begin
            errors++;
            $display("%0t: last_of_byte expected %0b, got %0b", $time, want.last, last_of_byte);
          end
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_byte(coded_byte, track_start);
    end
    fail_count <= errors;
    pending_words <= expected_words.size();
    checked_words <= words_seen;
  end

endmodule

// File: verif/tb_top.sv
// Top of the ADPCM decoder testbench: clock, reset, stimulus and the final verdict.
module tb_top;
  import vwadpcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the decoder settle after its last word before a register write,
  // and the quiet tail at the end of the run.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 30;

  // Register indexes that decode to nothing; writes there must leave the block alone.
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    coded_byte = '0;
  logic                          track_start = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [PCM_W-1:0]       pcm_sample;
  logic                          last_of_byte;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  int fail_count, pending_words, checked_words;

  // Percent of cycles in which the byte source holds off and the sample sink stalls.
  int send_gap_pct;
  int recv_stall_pct;
  int bytes_sent;
  int settings_loaded;

  variable_width_adpcm_decoder dut (.*);

  adpcm_word_checker checker_i (.*);

  initial forever #1 clk = ~clk;

  // The sink decides afresh at every edge whether it takes a word in the next cycle.
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Offers one byte, possibly after a random gap, and returns once the decoder takes it.
  // Valid stays high between back-to-back bytes so it is never dropped and raised in one step.
  task automatic push_byte(input logic [7:0] value, input logic new_track);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    coded_byte <= value;
    track_start <= new_track;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops the byte source and waits until every predicted word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all six registers in index order; the spare writes hit unused indexes.
  task automatic load_setting(input int init_idx, input int thresh, input int idx_lo,
                              input int idx_hi, input int pred_lo, input int pred_hi,
                              input bit with_spare);
    logic [CFG_INDEX_W-1:0] slots[$];
    logic [CFG_DATA_W-1:0]  values[$];
    slots = '{CFG_INITIAL_STEP_INDEX, CFG_WIDE_CODE_THRESHOLD, CFG_STEP_INDEX_FLOOR,
              CFG_STEP_INDEX_CEILING, CFG_PREDICTOR_FLOOR, CFG_PREDICTOR_CEILING};
    values = '{CFG_DATA_W'(init_idx), CFG_DATA_W'(thresh), CFG_DATA_W'(idx_lo),
               CFG_DATA_W'(idx_hi), CFG_DATA_W'(pred_lo), CFG_DATA_W'(pred_hi)};
    if (with_spare) begin
      slots.push_back(SPARE_INDEX_LO);
      values.push_back(12'hABC);
      slots.push_back(SPARE_INDEX_HI);
      values.push_back(12'h543);
    end
    foreach (slots[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= slots[k];
      cfg_data <= values[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Sets junk in the bits above a 7-bit register now and then; the block must drop them.
  function automatic int junk_high(input int value);
    return ($urandom_range(0, 3) == 0) ? (value | ($urandom_range(1, 31) << 7)) : value;
  endfunction

  // Mostly sane bounds, with start indexes past the table, crossed and
  // oversized bounds mixed in now and then.
  task automatic random_setting();
    int init_idx, thresh, idx_lo, idx_hi, pred_lo, pred_hi;
    init_idx = ($urandom_range(0, 7) == 0) ? $urandom_range(89, 127) : $urandom_range(0, 88);
    thresh = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 127) : $urandom_range(10, 40);
    idx_lo = $urandom_range(0, 30);
    idx_hi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(50, 88);
    pred_lo = ($urandom_range(0, 2) == 0) ? -2048 : -int'($urandom_range(0, 2048));
    pred_hi = ($urandom_range(0, 2) == 0) ? 2047 : int'($urandom_range(0, 2047));
    if ($urandom_range(0, 9) == 0) pred_lo = $urandom_range(0, 2047);
    load_setting(junk_high(init_idx), junk_high(thresh), junk_high(idx_lo),
                 junk_high(idx_hi), pred_lo, pred_hi, $urandom_range(0, 1));
  endtask

  // Sends bytes as tracks: a track start followed by a run of bytes with random codes.
  // A few tracks lack the start flag and a few stray starts land mid track.
  task automatic send_tracks(input int n_bytes);
    int left, run;
    left = n_bytes;
    while (left > 0) begin
      run = $urandom_range(1, 16);
      for (int k = 0; k < run && left > 0; k++) begin
        push_byte($urandom_range(0, 255),
                  (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0));
        left--;
      end
    end
  endtask

  initial begin
    send_gap_pct = 7;
    recv_stall_pct = 78;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: wide codes from the start. Large positive codes drive the
    // predictor into its ceiling and the step index into its bound, then large
    // negative codes drive it down to the floor.
    push_byte(8'h77, 1'b1);
    push_byte(8'h77, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    drain();

    // Start index past the table end (saturates to the last entry), threshold zero,
    // index ceiling above the table, widest predictor bounds, plus spare-index writes.
    load_setting(127, 0, 0, 127, -2048, 2047, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h88, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    drain();

    // Narrow codes only, crossed index bounds and crossed predictor bounds:
    // the ceiling wins in both.
    load_setting(0, 127, 60, 20, 500, -500, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hFF, 1'b0);
    drain();

    // The index climbs across the threshold mid byte, so a wide code starts at bit 2
    // and the last two bits fall back to a narrow code.
    load_setting(20, 22, 0, 88, -2048, 2047, 1'b0);
    push_byte(8'hC5, 1'b1);
    push_byte(8'h3D, 1'b1);
    push_byte(8'h81, 1'b1);
    drain();

    // Everything pinned at the top of the table: the index sits exactly at the
    // threshold, and the predictor bounds are narrow.
    load_setting(88, 88, 88, 88, -100, 100, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(8'hE7, 1'b0);
    push_byte(8'h00, 1'b0);
    drain();

    // Random part in three idling phases; each loads a fresh setting and drains
    // halfway through so the source also pauses with the pipe empty.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 7;
          recv_stall_pct = 78;
        end
        1: begin
          send_gap_pct = 78;
          recv_stall_pct = 7;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      random_setting();
      send_tracks(26);
      drain();
      send_tracks(26);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Decoded %0d bytes under %0d register settings; %0d PCM words compared.",
             bytes_sent, settings_loaded + 1, checked_words);
    $display("Covered wide and narrow codes, track starts, crossed and oversized bounds.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
sv/vwadpcm_pkg.sv
sv/variable_width_adpcm_decoder.sv
verif/adpcm_word_checker.sv
verif/tb_top.sv
